FILE: rtl/core/m3sfq_pkg.sv
// Package for the median-of-three sensor fault qualifier.
// Holds field widths, reset values, register index codes and the fault status struct.
// No dependencies.
package m3sfq_pkg;

   localparam int SAMPLE_BITS      = 12;
   localparam int IDX_BITS         = 2;
   localparam int CNT_BITS         = 8;
   localparam int SENSOR_COUNT_DEF = 3;
   localparam int CSR_IDX_BITS     = 1;
   localparam int REQ_FIELD_BITS   = 3 * SAMPLE_BITS;
   localparam int REQ_TDATA_BITS   = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS   = SAMPLE_BITS + 4;
   localparam int RSP_TDATA_BITS   = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [SAMPLE_BITS-1:0] ADC_MAX_RESET   = SAMPLE_BITS'(1023);
   localparam logic [CNT_BITS-1:0]    THRESHOLD_RESET = CNT_BITS'(50);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ADC_MAX         = 1'b0,
      CSR_FAULT_THRESHOLD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic active;
      logic raised;
      logic any;
   } fault_status_type;

endpackage

FILE: rtl/core/m3sfq_median.sv
// Median of three samples and range check against the converter maximum.
// Combinational; uses m3sfq_pkg.
module m3sfq_median (
   input  logic [m3sfq_pkg::SAMPLE_BITS-1:0] sample_a,
   input  logic [m3sfq_pkg::SAMPLE_BITS-1:0] sample_b,
   input  logic [m3sfq_pkg::SAMPLE_BITS-1:0] sample_c,
   input  logic [m3sfq_pkg::SAMPLE_BITS-1:0] adc_max,
   output logic [m3sfq_pkg::SAMPLE_BITS-1:0] median,
   output logic                              invalid
);
   import m3sfq_pkg::*;

   always_comb begin
      if (sample_a > sample_b) begin
         if (sample_b > sample_c) begin
            median = sample_b;
         end else begin
            median = (sample_a > sample_c) ? sample_c : sample_a;
         end
      end else if (sample_a > sample_c) begin
         median = sample_a;
      end else begin
         median = (sample_b > sample_c) ? sample_c : sample_b;
      end
   end

   assign invalid = (median == '0) || (median >= adc_max);

endmodule

FILE: rtl/core/m3sfq_fault_track.sv
// Per-sensor invalid counters and fault flags with the post-update status.
// Uses m3sfq_pkg.
module m3sfq_fault_track #(
   parameter int SENSOR_COUNT = m3sfq_pkg::SENSOR_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                update,
   input  logic [m3sfq_pkg::IDX_BITS-1:0]      sensor_index,
   input  logic                                bad,
   input  logic [m3sfq_pkg::CNT_BITS-1:0]      threshold,
   output m3sfq_pkg::fault_status_type         status
);
   import m3sfq_pkg::*;

   logic [CNT_BITS-1:0] count_ff [SENSOR_COUNT];
   logic [CNT_BITS-1:0] count_in [SENSOR_COUNT];
   logic                flag_ff  [SENSOR_COUNT];
   logic                flag_in  [SENSOR_COUNT];
   logic [CNT_BITS-1:0] count_inc [SENSOR_COUNT];
   logic                hit      [SENSOR_COUNT];
   logic                reached  [SENSOR_COUNT];

   always_comb begin
      status = '0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
         hit[k]       = (int'(sensor_index) == k);
         count_inc[k] = (count_ff[k] < threshold) ? count_ff[k] + CNT_BITS'(1) : count_ff[k];
         reached[k]   = (count_inc[k] >= threshold);
         if (hit[k]) begin
            count_in[k] = bad ? count_inc[k] : '0;
            flag_in[k]  = bad && (flag_ff[k] || reached[k]);
         end else begin
            count_in[k] = count_ff[k];
            flag_in[k]  = flag_ff[k];
         end
         status.active = status.active | (hit[k] & flag_in[k]);
         status.raised = status.raised | (hit[k] & bad & reached[k] & ~flag_ff[k]);
         status.any    = status.any | flag_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SENSOR_COUNT; k++) begin
         if (reset) begin
            count_ff[k] <= '0;
            flag_ff[k]  <= 1'b0;
         end else if (update) begin
            count_ff[k] <= count_in[k];
            flag_ff[k]  <= flag_in[k];
         end
      end
   end

endmodule

FILE: rtl/core/median3_sensor_fault_qualifier_core.sv
// Top level of the median-of-three sensor fault qualifier.
// Uses m3sfq_pkg, m3sfq_median and m3sfq_fault_track.
//
// Usage:
//   req_*  input stream. tuser carries the sensor index, tdata the three
//          samples. One item per burst of three converter samples.
//   rsp_*  result stream, exactly one item per input item, in order. tuser
//          echoes the sensor index; tdata holds median and status flags.
//   csr_*  register writes: index 0 sets the converter maximum, index 1 the
//          fault threshold. Write only while no item is in flight.
// Path: an accepted req is captured in the input register, then in the result
//   register, which drives rsp_tvalid; median, range check and counter
//   update sit between the two registers.
// Throughput: one item per cycle while rsp is taken; the result register and
//   the input register run as a two-entry pipeline.
// Reset clears counters and fault flags, loads the converter maximum 1023
//   and threshold 50, and empties both registers.
// When the receiver stalls, the result holds; one more item is taken into
//   the input register, then req_tready drops until rsp is taken.
module median3_sensor_fault_qualifier_core #(
   parameter int SENSOR_COUNT = m3sfq_pkg::SENSOR_COUNT_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // sample_first, sample_second, sample_third, zero pad
   input  logic [m3sfq_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   // sensor_index
   input  logic [m3sfq_pkg::IDX_BITS-1:0]          req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // median_value, median_invalid, fault_active, fault_raised, any_fault
   output logic [m3sfq_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   // sensor_out
   output logic [m3sfq_pkg::IDX_BITS-1:0]          rsp_tuser,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [m3sfq_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [m3sfq_pkg::SAMPLE_BITS-1:0]       csr_data
);
   import m3sfq_pkg::*;

   logic [SAMPLE_BITS-1:0]    adc_max_ff, adc_max_in;
   logic [CNT_BITS-1:0]       threshold_ff, threshold_in;

   logic                      in_valid_ff, in_valid_in;
   logic [IDX_BITS-1:0]       in_idx_ff, in_idx_in;
   logic [REQ_FIELD_BITS-1:0] in_samples_ff, in_samples_in;

   logic                      out_valid_ff, out_valid_in;
   logic [IDX_BITS-1:0]       out_idx_ff, out_idx_in;
   logic [RSP_TDATA_BITS-1:0] out_data_ff, out_data_in;

   logic                      advance;
   logic                      update;
   logic [SAMPLE_BITS-1:0]    median;
   logic                      invalid;
   fault_status_type          status;

   assign csr_ready = 1'b1;

   always_comb begin
      adc_max_in   = adc_max_ff;
      threshold_in = threshold_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ADC_MAX:         adc_max_in   = csr_data;
            CSR_FAULT_THRESHOLD: threshold_in = csr_data[CNT_BITS-1:0];
            default:             adc_max_in   = adc_max_ff;
         endcase
      end
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign update     = in_valid_ff && advance;

   m3sfq_median u_median (
      .sample_a (in_samples_ff[SAMPLE_BITS-1:0]),
      .sample_b (in_samples_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .sample_c (in_samples_ff[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
      .adc_max  (adc_max_ff),
      .median   (median),
      .invalid  (invalid)
   );

   m3sfq_fault_track #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_fault_track (
      .clock        (clock),
      .reset        (reset),
      .update       (update),
      .sensor_index (in_idx_ff),
      .bad          (invalid),
      .threshold    (threshold_ff),
      .status       (status)
   );

   always_comb begin
      in_valid_in   = req_tready ? req_tvalid : in_valid_ff;
      in_idx_in     = in_idx_ff;
      in_samples_in = in_samples_ff;
      if (req_tvalid && req_tready) begin
         in_idx_in     = req_tuser;
         in_samples_in = req_tdata[REQ_FIELD_BITS-1:0];
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_data_in  = out_data_ff;
      if (update) begin
         out_idx_in  = in_idx_ff;
         out_data_in = RSP_TDATA_BITS'({status.any, status.raised, status.active,
                                        invalid, median});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_max_ff   <= ADC_MAX_RESET;
         threshold_ff <= THRESHOLD_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         adc_max_ff   <= adc_max_in;
         threshold_ff <= threshold_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_idx_ff     <= in_idx_in;
      in_samples_ff <= in_samples_in;
      out_idx_ff    <= out_idx_in;
      out_data_ff   <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_idx_ff;

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_samples_ff)
                                     && $stable(in_idx_ff)))
      else $error("input register lost or changed a stalled item");

   a_raise_needs_bad: assert property (@(posedge clock) disable iff (reset)
      (update && status.raised) |-> (invalid && status.active && status.any))
      else $error("fault raised without an invalid median");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (out_valid_ff && !rsp_tready && in_valid_ff))
      else $error("input stalled while the result side was free");

endmodule
